### hdl/shbc_pkg.sv
package shbc_pkg;

    // Table geometry
    localparam int BUCKET_BITS = 16;
    localparam int NUM_SAMPLES = 2;
    localparam int SAMPLE_W    = $clog2(NUM_SAMPLES);
    localparam int ADDR_W      = SAMPLE_W + BUCKET_BITS;
    localparam int TABLE_DEPTH = 2 ** ADDR_W;

    // Field widths
    localparam int HASH_W     = 64;
    localparam int CMD_W      = 1;
    localparam int BKT_FLD_W  = 16;
    localparam int COUNT_W    = 16;
    localparam int TOTAL_W    = 40;
    localparam int SBITS_W    = 6;

    // Sample selection
    localparam logic [SBITS_W-1:0] SBITS_RESET = SBITS_W'(11);
    localparam logic [SBITS_W-1:0] SBITS_MIN   = SBITS_W'(2);
    localparam logic [SBITS_W-1:0] SBITS_MAX   = SBITS_W'(32);
    localparam logic [SBITS_W:0]   SHIFT_TOP0  = (SBITS_W+1)'(63);
    localparam logic [SBITS_W:0]   SHIFT_TOP1  = (SBITS_W+1)'(64);
    localparam logic [HASH_W-1:0]  HASH_ONE    = HASH_W'(1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_HASH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    // What the back end does with a queued request
    typedef enum logic [1:0] {
        OP_SKIP  = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind                  kind;
        logic [SAMPLE_W-1:0]       sample;
        logic [BUCKET_BITS-1:0]    bucket;
        logic [TOTAL_W-1:0]        total;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hdl/shbc_in_if.sv
interface shbc_in_if;
    logic                         valid;
    logic                         ready;
    logic [shbc_pkg::CMD_W-1:0]   cmd;
    logic [shbc_pkg::HASH_W-1:0]  hash_value;
    logic                         read_sample;
    logic [15:0]                  read_bucket;

    modport source (output valid, cmd, hash_value, read_sample, read_bucket, input ready);
    modport sink   (input valid, cmd, hash_value, read_sample, read_bucket, output ready);
endinterface

### hdl/shbc_out_if.sv
interface shbc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             sampled;
    logic                             sample_index;
    logic [shbc_pkg::BKT_FLD_W-1:0]   bucket;
    logic [shbc_pkg::COUNT_W-1:0]     count;
    logic [shbc_pkg::TOTAL_W-1:0]     total_hashes;

    modport source (output valid, sampled, sample_index, bucket, count, total_hashes,
                    input ready);
    modport sink   (input valid, sampled, sample_index, bucket, count, total_hashes,
                    output ready);
endinterface

### hdl/shbc_front.sv
module shbc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [shbc_pkg::SBITS_W-1:0]  i_cfg_wdata,
    input  logic                          i_clearing,
    input  shbc_pkg::t_q_stat             i_q_stat,
    shbc_in_if.sink                       i_in,
    output logic                          o_push,
    output shbc_pkg::t_op                 o_op
);
    import shbc_pkg::*;

    logic [SBITS_W-1:0] r_sbits;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [SBITS_W-1:0] s_eff;
    logic [SBITS_W-1:0] sh0;
    logic [SBITS_W-1:0] sh1;
    logic [HASH_W-1:0]  mask1;
    logic               hit0;
    logic               hit1;
    logic               is_read;

    // Take a request while the queue has room and the table is not being cleared
    assign i_in.ready = !i_q_stat.full && !i_clearing;
    assign o_push     = i_in.valid && i_in.ready;
    assign is_read    = (i_in.cmd == CMD_READ);

    // Clamp the sample width into its legal range
    always_comb begin
        if (r_sbits < SBITS_MIN) begin
            s_eff = SBITS_MIN;
        end else if (r_sbits > SBITS_MAX) begin
            s_eff = SBITS_MAX;
        end else begin
            s_eff = r_sbits;
        end
    end

    // Test the leading hash bits against both sample patterns
    assign sh0   = SBITS_W'(SHIFT_TOP0 - {1'b0, s_eff});
    assign sh1   = SBITS_W'(SHIFT_TOP1 - {1'b0, s_eff});
    assign mask1 = (HASH_ONE << (s_eff - SBITS_W'(1))) - HASH_ONE;
    assign hit0  = ((i_in.hash_value >> sh0) == HASH_ONE);
    assign hit1  = ((i_in.hash_value >> sh1) == mask1);

    // Advance the saturating total on every hash request
    always_comb begin
        n_total = r_total;
        if (o_push && !is_read && (r_total != TOTAL_MAX)) begin
            n_total = r_total + TOTAL_W'(1);
        end
    end

    // Classify the request for the back end
    always_comb begin
        o_op.total = n_total;
        if (is_read) begin
            o_op.kind   = OP_READ;
            o_op.sample = SAMPLE_W'(i_in.read_sample);
            o_op.bucket = BUCKET_BITS'(i_in.read_bucket);
        end else if (hit1) begin
            o_op.kind   = OP_COUNT;
            o_op.sample = SAMPLE_W'(1);
            o_op.bucket = i_in.hash_value[BUCKET_BITS-1:0];
        end else if (hit0) begin
            o_op.kind   = OP_COUNT;
            o_op.sample = SAMPLE_W'(0);
            o_op.bucket = i_in.hash_value[BUCKET_BITS-1:0];
        end else begin
            o_op.kind   = OP_SKIP;
            o_op.sample = '0;
            o_op.bucket = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbits <= SBITS_RESET;
            r_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sbits <= i_cfg_wdata;
            end
            r_total <= n_total;
        end
    end

endmodule

### hdl/shbc_queue.sv
module shbc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  shbc_pkg::t_op      i_op,
    input  logic               i_pop,
    output shbc_pkg::t_op      o_head,
    output shbc_pkg::t_q_stat  o_stat
);
    import shbc_pkg::*;

    t_op        r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_head       = r_slot[r_rptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Hold classified requests in order
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/shbc_back.sv
module shbc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shbc_pkg::t_op      i_head,
    input  shbc_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    output logic               o_clearing,
    shbc_out_if.source         o_out
);
    import shbc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_RMW   = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [COUNT_W-1:0]   r_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0]   r_rd_data;
    t_op                  r_op;
    logic                 r_out_valid;
    logic                 r_sampled;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [BKT_FLD_W-1:0] r_bucket;
    logic [COUNT_W-1:0]   r_count;
    logic [TOTAL_W-1:0]   r_total;

    logic                 out_free;
    logic                 load_skip;
    logic                 load_rmw;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [COUNT_W-1:0]   mem_wdata;
    logic [COUNT_W-1:0]   new_count;

    assign o_clearing = (r_state == S_CLEAR);
    assign out_free   = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty && out_free;
    assign load_skip  = o_pop && (i_head.kind == OP_SKIP);
    assign load_rmw   = (r_state == S_RMW);
    assign new_count  = (r_op.kind == OP_COUNT) ? r_rd_data + COUNT_W'(1) : r_rd_data;

    // Sequence clear, idle and read-modify-write
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop && (i_head.kind != OP_SKIP)) begin
                    n_state = S_RMW;
                end
            end
            S_RMW:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Select the memory write: clearing sweep or counter update
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (load_rmw && (r_op.kind == OP_COUNT)) begin
            mem_we    = 1'b1;
            mem_waddr = {r_op.sample, r_op.bucket};
            mem_wdata = new_count;
        end
    end

    // Counter table with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[{i_head.sample, i_head.bucket}];
        end
    end

    // Hold the popped request and the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head;
        end
        if (load_skip) begin
            r_sampled <= 1'b0;
            r_sample  <= '0;
            r_bucket  <= '0;
            r_count   <= '0;
            r_total   <= i_head.total;
        end else if (load_rmw) begin
            r_sampled <= 1'b1;
            r_sample  <= r_op.sample;
            r_bucket  <= BKT_FLD_W'(r_op.bucket);
            r_count   <= new_count;
            r_total   <= r_op.total;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (load_skip || load_rmw) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sampled      = r_sampled;
    assign o_out.sample_index = r_sample;
    assign o_out.bucket       = r_bucket;
    assign o_out.count        = r_count;
    assign o_out.total_hashes = r_total;

endmodule

### hdl/sampled_hash_bucket_counter_core.sv
// Sampled hash bucket counter. Hash requests are classified against the
// sample_bits register into sample 0, sample 1 or neither; a sampled hash
// bumps a wrapping 16-bit counter in that sample's table at the bucket taken
// from its low bits, and every hash request advances a saturating 40-bit
// total. A read request returns one counter without changing state. The front
// end takes one request per cycle into a two-entry queue while the queue has
// room and no clear is running; the back end handles a request that touches
// the counter memory as a registered read, then the counter write for a hash
// and the result, and takes an unsampled hash straight to a result. It takes
// no new request during a read-modify-write or while a result waits unaccepted.
// After reset the back end clears the 131072-entry counter memory one entry per
// cycle, and no request is taken until the clear is done; sample_bits may be
// written at any time the block is idle, including during the clear.
module sampled_hash_bucket_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [shbc_pkg::SBITS_W-1:0]  i_cfg_wdata,
    shbc_in_if.sink                       i_in,
    shbc_out_if.source                    o_out
);
    import shbc_pkg::*;

    logic    push;
    logic    pop;
    logic    clearing;
    t_op     front_op;
    t_op     head_op;
    t_q_stat q_stat;

    // Classify requests and keep the running total
    shbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_clearing  (clearing),
        .i_q_stat    (q_stat),
        .i_in        (i_in),
        .o_push      (push),
        .o_op        (front_op)
    );

    // Decouple front and back
    shbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_stat  (q_stat)
    );

    // Update or read the counter tables
    shbc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_op),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import shbc_pkg::*;

    localparam int          PHASES         = 10;
    localparam int          ITEMS_PER_PHASE = 193;
    localparam int          TAIL_ITEMS     = 250;
    localparam int          CFG_SETTLE     = 4;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          STALL_CYCLES   = 120;
    localparam int          STALL_EVERY    = 600;
    localparam int          WATCHDOG_LIMIT = 600000;

    typedef struct {
        bit                  is_cfg;
        logic [SBITS_W-1:0]  sbits;
        logic [CMD_W-1:0]    cmd;
        logic [HASH_W-1:0]   hash;
        logic                rd_sample;
        logic [15:0]         rd_bucket;
    } t_hash_req;

    typedef struct {
        logic                  sampled;
        logic                  sample_index;
        logic [BKT_FLD_W-1:0]  bucket;
        logic [COUNT_W-1:0]    count;
        logic [TOTAL_W-1:0]    total;
    } t_bucket_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [SBITS_W-1:0] i_cfg_wdata;

    shbc_in_if  in_bus ();
    shbc_out_if out_bus ();

    sampled_hash_bucket_counter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // Shadow copy of the counter tables, the total and the register
    bit   [COUNT_W-1:0] shadow_counters [NUM_SAMPLES][2**BUCKET_BITS];
    logic [TOTAL_W-1:0] shadow_total = '0;
    logic [SBITS_W-1:0] shadow_sbits = SBITS_RESET;

    t_hash_req      pending_reqs[$];
    t_bucket_result bucket_results_q[$];
    t_hash_req      cur_req;

    logic [15:0] hot_buckets [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                     16'h1234, 16'hAAAA, 16'h5555, 16'h00FF};

    int unsigned n_mismatch = 0;
    int unsigned src_gap    = 0;
    int unsigned src_calm   = 0;
    int unsigned cfg_wait   = 0;
    int unsigned sink_gap   = 0;
    int unsigned sink_calm  = 0;
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;
    int unsigned drained    = 0;
    int unsigned idle_run   = 0;
    bit          quiet_tail = 1'b0;

    // Clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(string what);
        if (n_mismatch < 50) $display("[%0t] MISMATCH %s", $time, what);
        n_mismatch++;
    endtask

    function automatic int unsigned clamp_sbits(logic [SBITS_W-1:0] v);
        if (v < SBITS_MIN) return SBITS_MIN;
        if (v > SBITS_MAX) return SBITS_MAX;
        return v;
    endfunction

    // Build a hash that carries the sample 0 or sample 1 prefix for width s
    function automatic logic [HASH_W-1:0] shape_hash(bit to_s1, int unsigned s,
                                                     logic [HASH_W-1:0] fill);
        logic [HASH_W-1:0] low_mask;
        if (to_s1) begin
            low_mask = (HASH_ONE << (SHIFT_TOP1 - s)) - HASH_ONE;
            return (fill & low_mask) |
                   (((HASH_ONE << (s - 1)) - HASH_ONE) << (SHIFT_TOP1 - s));
        end
        low_mask = (HASH_ONE << (SHIFT_TOP0 - s)) - HASH_ONE;
        return (fill & low_mask) | (HASH_ONE << (SHIFT_TOP0 - s));
    endfunction

    // Classify and count one request against the shadow state
    function automatic t_bucket_result tally_request(t_hash_req r);
        t_bucket_result         res;
        int unsigned            s;
        logic [BUCKET_BITS-1:0] bk;
        logic [HASH_W-1:0]      ones1;
        bit                     hit;
        logic                   smp;
        res = '{default: '0};
        if (r.cmd == CMD_READ) begin
            bk = BUCKET_BITS'(r.rd_bucket);
            res.sampled      = 1'b1;
            res.sample_index = r.rd_sample;
            res.bucket       = BKT_FLD_W'(bk);
            res.count        = shadow_counters[r.rd_sample][bk];
            res.total        = shadow_total;
            return res;
        end
        if (shadow_total != TOTAL_MAX) shadow_total++;
        s     = clamp_sbits(shadow_sbits);
        ones1 = (HASH_ONE << (s - 1)) - HASH_ONE;
        hit   = 1'b0;
        smp   = 1'b0;
        if ((r.hash >> (SHIFT_TOP0 - s)) == HASH_ONE) begin
            hit = 1'b1;
            smp = 1'b0;
        end
        // sample 1 wins when both prefixes match
        if ((r.hash >> (SHIFT_TOP1 - s)) == ones1) begin
            hit = 1'b1;
            smp = 1'b1;
        end
        if (hit) begin
            bk = r.hash[BUCKET_BITS-1:0];
            shadow_counters[smp][bk] += 1'b1;
            res.sampled      = 1'b1;
            res.sample_index = smp;
            res.bucket       = BKT_FLD_W'(bk);
            res.count        = shadow_counters[smp][bk];
        end
        res.total = shadow_total;
        return res;
    endfunction

    // Mostly well-formed sampled hashes and reads on a few hot buckets, plus noise
    function automatic t_hash_req random_request(int unsigned s);
        t_hash_req         r;
        int unsigned       pick;
        logic [HASH_W-1:0] fill;
        logic [15:0]       bkt;
        fill = {$urandom, $urandom};
        bkt  = ($urandom_range(0, 9) < 6) ? hot_buckets[$urandom_range(0, 7)]
                                          : 16'($urandom);
        r.is_cfg    = 1'b0;
        r.sbits     = '0;
        r.cmd       = CMD_HASH;
        r.hash      = fill;
        r.rd_sample = $urandom_range(0, 1);
        r.rd_bucket = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r.cmd       = CMD_READ;
            r.rd_bucket = bkt;
        end else if (pick < 90) begin
            r.hash       = shape_hash($urandom_range(0, 1), s, fill);
            r.hash[15:0] = bkt;
            // near miss: break one bit of the prefix
            if (pick >= 80) r.hash[63 - $urandom_range(0, s)] ^= 1'b1;
        end
        return r;
    endfunction

    task automatic push_item(logic [CMD_W-1:0] cmd, logic [HASH_W-1:0] hash,
                             logic rs, logic [15:0] rb);
        t_hash_req r;
        r.is_cfg    = 1'b0;
        r.sbits     = '0;
        r.cmd       = cmd;
        r.hash      = hash;
        r.rd_sample = rs;
        r.rd_bucket = rb;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        bit fired;
        bit nxt_valid;
        bit write_cfg;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            i_cfg_we     <= 1'b0;
        end else begin
            fired     = in_bus.valid && in_bus.ready;
            nxt_valid = in_bus.valid && !fired;
            write_cfg = 1'b0;
            if (fired) begin
                bucket_results_q.insert(bucket_results_q.size(), tally_request(cur_req));
                if (src_calm != 0) begin
                    src_calm--;
                end else if (!quiet_tail) begin
                    if ($urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
                    else if ($urandom_range(0, 40) == 0) src_calm = $urandom_range(20, 100);
                end
            end
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (pending_reqs.size() != 0) begin
                    if (pending_reqs[0].is_cfg) begin
                        // write the register only once the block has drained
                        if (bucket_results_q.size() == 0) cfg_wait++;
                        else cfg_wait = 0;
                        if (cfg_wait >= CFG_SETTLE) begin
                            write_cfg    = 1'b1;
                            shadow_sbits = pending_reqs[0].sbits;
                            i_cfg_wdata  <= pending_reqs[0].sbits;
                            void'(pending_reqs.pop_front());
                            cfg_wait = 0;
                        end
                    end else begin
                        cur_req   = pending_reqs.pop_front();
                        nxt_valid = 1'b1;
                        in_bus.cmd         <= cur_req.cmd;
                        in_bus.hash_value  <= cur_req.hash;
                        in_bus.read_sample <= cur_req.rd_sample;
                        in_bus.read_bucket <= cur_req.rd_bucket;
                    end
                end
            end
            in_bus.valid <= nxt_valid;
            i_cfg_we     <= write_cfg;
            quiet_tail   <= (pending_reqs.size() < TAIL_ITEMS);
        end
    end

    // Result ready: random bursts, calm stretches and a couple of long holds
    always @(posedge i_clk) begin
        bit nr;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b1;
        end else begin
            if (out_bus.valid && out_bus.ready) drained++;
            nr = 1'b1;
            if (hold_left != 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                nr = 1'b0;
            end else if (holds_done < 2 && drained >= (holds_done + 1) * STALL_EVERY) begin
                hold_left = STALL_CYCLES - 1;
                holds_done++;
                nr = 1'b0;
            end else if (!quiet_tail) begin
                if (sink_calm != 0) begin
                    sink_calm--;
                end else if ($urandom_range(0, 5) == 0) begin
                    sink_gap = $urandom_range(1, 9) - 1;
                    nr = 1'b0;
                end else if ($urandom_range(0, 30) == 0) begin
                    sink_calm = $urandom_range(20, 100);
                end
            end
            out_bus.ready <= nr;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_bucket_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (bucket_results_q.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = bucket_results_q.pop_front();
                if (out_bus.sampled !== want.sampled)
                    report_mismatch($sformatf("sampled got %b want %b",
                                              out_bus.sampled, want.sampled));
                if (out_bus.sample_index !== want.sample_index)
                    report_mismatch($sformatf("sample_index got %b want %b",
                                              out_bus.sample_index, want.sample_index));
                if (out_bus.bucket !== want.bucket)
                    report_mismatch($sformatf("bucket got %h want %h",
                                              out_bus.bucket, want.bucket));
                if (out_bus.count !== want.count)
                    report_mismatch($sformatf("count got %h want %h",
                                              out_bus.count, want.count));
                if (out_bus.total_hashes !== want.total)
                    report_mismatch($sformatf("total_hashes got %h want %h",
                                              out_bus.total_hashes, want.total));
            end
        end
    end

    // Watchdog on cycles without any handshake; covers the clear after reset
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_hash_req          r;
        logic [SBITS_W-1:0] phase_sbits [PHASES];
        int unsigned        s;
        phase_sbits = '{6'd11, 6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd5, 6'd24, 6'd16};

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = SBITS_RESET;
        in_bus.valid       = 1'b0;
        in_bus.cmd         = CMD_HASH;
        in_bus.hash_value  = '0;
        in_bus.read_sample = 1'b0;
        in_bus.read_bucket = '0;
        out_bus.ready      = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            r        = '{default: '0};
            r.is_cfg = 1'b1;
            r.sbits  = phase_sbits[ph];
            pending_reqs.insert(pending_reqs.size(), r);
            s = clamp_sbits(phase_sbits[ph]);
            if (ph == 0) begin
                // zero and all-ones hashes, prefix extremes, repeat hits
                push_item(CMD_HASH, '0, 1'b0, 16'h0000);
                push_item(CMD_HASH, '1, 1'b1, 16'hFFFF);
                push_item(CMD_HASH, shape_hash(1'b0, s, '0), 1'b0, 16'h0000);
                push_item(CMD_HASH, shape_hash(1'b0, s, '1), 1'b1, 16'hFFFF);
                push_item(CMD_HASH, shape_hash(1'b1, s, '0), 1'b0, 16'h0000);
                push_item(CMD_HASH, shape_hash(1'b1, s, '1), 1'b1, 16'hFFFF);
                push_item(CMD_HASH, shape_hash(1'b0, s, '0), 1'b0, 16'h0000);
                push_item(CMD_HASH, shape_hash(1'b1, s, '1), 1'b0, 16'h0000);
                // reads of touched and untouched counters
                push_item(CMD_READ, '0, 1'b0, 16'h0000);
                push_item(CMD_READ, '0, 1'b0, 16'hFFFF);
                push_item(CMD_READ, '0, 1'b1, 16'h0000);
                push_item(CMD_READ, '1, 1'b1, 16'hFFFF);
                push_item(CMD_READ, '0, 1'b1, 16'h1234);
                // near misses on each prefix
                push_item(CMD_HASH, shape_hash(1'b1, s, '0) ^ (HASH_ONE << 63), 1'b0, 16'h0);
                push_item(CMD_HASH, shape_hash(1'b0, s, '1) ^ (HASH_ONE << (SHIFT_TOP0 - s)),
                          1'b0, 16'h0);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                pending_reqs.insert(pending_reqs.size(), random_request(s));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || in_bus.valid || bucket_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && bucket_results_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
